>>> hdl/first_fit_block_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator
// Shared forms of the concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define FFBA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that implies a result in the following cycle.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Codes, register indexes and sequencer states of the block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_RESIZE  = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

    localparam logic       REG_SPLIT_MARGIN = 1'b0;
    localparam logic [7:0] MARGIN_RESET     = 8'd16;

    typedef enum logic {
        SCAN_USED,
        SCAN_FREE
    } scan_mode_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_SCAN0,
        S_SCAN,
        S_DISP,
        S_AL_FOUND,
        S_AL_RES,
        S_RS_RD,
        S_RS_CHK,
        S_RS_RES,
        S_SP_CHK,
        S_SU_RD,
        S_SU_WR,
        S_SP_INS,
        S_SP_M,
        S_SP_WB,
        S_REM_RD,
        S_REM_WR,
        S_REL0,
        S_REL1,
        S_REL2,
        S_REL3,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hdl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Block table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 41
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap allocator with coalescing over an address-ordered block table.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Contents
//  s_*       request    s_tvalid/s_tready  tuser kind, tdata address, size
//  m_*       response   m_tvalid/m_tready  tuser status, tdata result fields
//  APB       config     psel/penable       split_margin at byte address 0
//
// One request is a chain of table passes: a scan reads each block entry in
// turn, and every entry moved by an insert or removal goes through the
// single table memory port pair. A worst-case relocating resize runs to seven
// passes over the table: three scans and four entry moves. After reset the
// block writes the initial free block in S_INIT before it raises s_tready.
// A waiting response does not stall the next request; only the final
// hand-off waits for the output slot.
//
`default_nettype none

module first_fit_block_allocator_top
    import ffba_pkg::*;
#(
    parameter int POOL_BYTES   = 1048576,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // address[19:0], request_size[40:20], zero pad
    input  wire logic [1:0]  s_tuser,  // kind[1:0]
    // Response stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,  // result_address[19:0], block_size[40:20],
                                       // moved[41], copy_length[62:42], zero pad
    output logic      [1:0]  m_tuser,  // status[1:0]
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // Offsets and sizes are below the pool size; arithmetic runs a little wider
    // so that a rounded request plus header and margin never wraps.
    localparam int AW  = $clog2(POOL_BYTES);
    localparam int CW  = ((AW > 21) ? AW : 21) + 2;
    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int CNW = IW + 1;
    localparam int EW  = 2 * AW + 1;

    localparam logic [CW-1:0]  HDR     = CW'(HEADER_BYTES);
    localparam logic [AW-1:0]  INIT_P  = AW'(POOL_BYTES - HEADER_BYTES);
    localparam logic [CNW-1:0] MAX_CNT = CNW'(MAX_BLOCKS);

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    state_t           sret_reg, sret_next;
    scan_mode_t       mode_reg, mode_next;
    logic             reloc_reg, reloc_next;
    logic [1:0]       kind_reg, kind_next;
    logic [19:0]      addr_reg, addr_next;
    logic [CW-1:0]    size_reg, size_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CNW-1:0]   scan_reg, scan_next;
    logic [IW-1:0]    cmp_reg, cmp_next;
    logic             pv_reg, pv_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [CNW-1:0]   count_reg, count_next;
    logic [AW-1:0]    cs_reg, cs_next;
    logic [AW-1:0]    cp_reg, cp_next;
    logic             cf_reg, cf_next;
    logic [AW-1:0]    ns_reg, ns_next;
    logic [AW-1:0]    np_reg, np_next;
    logic [AW-1:0]    old_reg, old_next;
    logic [1:0]       rstat_reg, rstat_next;
    logic [19:0]      raddr_reg, raddr_next;
    logic [20:0]      rsize_reg, rsize_next;
    logic             rmoved_reg, rmoved_next;
    logic [20:0]      rcopy_reg, rcopy_next;
    logic [7:0]       margin_reg;
    logic             mvalid_reg, mvalid_next;
    logic [1:0]       muser_reg, muser_next;
    logic [63:0]      mdata_reg, mdata_next;

    // Table memory ports; entries are packed as {free, payload, start}.
    logic             we;
    logic [IW-1:0]    waddr;
    logic [EW-1:0]    wdata;
    logic [IW-1:0]    rd_addr;
    logic [EW-1:0]    rdata;
    logic [AW-1:0]    rd_s;
    logic [AW-1:0]    rd_p;
    logic             rd_f;

    ffba_ram #(
        .DEPTH(MAX_BLOCKS),
        .WIDTH(EW)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    assign rd_s = rdata[AW-1:0];
    assign rd_p = rdata[2*AW-1:AW];
    assign rd_f = rdata[2*AW];

    // Helper values shared by several states.
    logic [CNW-1:0] idx_p1;
    logic [CNW-1:0] idx_p2;
    logic [CNW-1:0] j_p1;
    logic [CW-1:0]  in_size;
    logic [CW-1:0]  cp_plus_next;
    logic           hit;

    assign idx_p1       = CNW'(idx_reg) + CNW'(1);
    assign idx_p2       = CNW'(idx_reg) + CNW'(2);
    assign j_p1         = CNW'(j_reg) + CNW'(1);
    assign in_size      = (CW'(s_tdata[40:20]) + CW'(7)) & ~CW'(7);
    assign cp_plus_next = CW'(cp_reg) + HDR + CW'(rd_p);

    always_comb
    begin
        if (mode_reg == SCAN_FREE)
        begin
            hit = pv_reg && rd_f && (CW'(rd_p) >= size_reg);
        end
        else
        begin
            hit = pv_reg && !rd_f && ((CW'(rd_s) + HDR) == CW'(addr_reg));
        end
    end

    // Configuration register: the user writes it only while no request is in flight; the block does not enforce this.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SPLIT_MARGIN) ? {24'd0, margin_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_SPLIT_MARGIN))
        begin
            margin_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg    <= ret_next;
        sret_reg   <= sret_next;
        mode_reg   <= mode_next;
        reloc_reg  <= reloc_next;
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        size_reg   <= size_next;
        idx_reg    <= idx_next;
        scan_reg   <= scan_next;
        cmp_reg    <= cmp_next;
        pv_reg     <= pv_next;
        j_reg      <= j_next;
        cs_reg     <= cs_next;
        cp_reg     <= cp_next;
        cf_reg     <= cf_next;
        ns_reg     <= ns_next;
        np_reg     <= np_next;
        old_reg    <= old_next;
        rstat_reg  <= rstat_next;
        raddr_reg  <= raddr_next;
        rsize_reg  <= rsize_next;
        rmoved_reg <= rmoved_next;
        rcopy_reg  <= rcopy_next;
        muser_reg  <= muser_next;
        mdata_reg  <= mdata_next;
    end

    // Sequencer: every table walk, insert gap, removal and merge is a chain of
    // states sharing the one table memory.
    always_comb
    begin
        logic [CW-1:0] tmp;
        state_next  = state_reg;
        ret_next    = ret_reg;
        sret_next   = sret_reg;
        mode_next   = mode_reg;
        reloc_next  = reloc_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        size_next   = size_reg;
        idx_next    = idx_reg;
        scan_next   = scan_reg;
        cmp_next    = cmp_reg;
        pv_next     = pv_reg;
        j_next      = j_reg;
        count_next  = count_reg;
        cs_next     = cs_reg;
        cp_next     = cp_reg;
        cf_next     = cf_reg;
        ns_next     = ns_reg;
        np_next     = np_reg;
        old_next    = old_reg;
        rstat_next  = rstat_reg;
        raddr_next  = raddr_reg;
        rsize_next  = rsize_reg;
        rmoved_next = rmoved_reg;
        rcopy_next  = rcopy_reg;
        muser_next  = muser_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg && !m_tready;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = {cf_reg, cp_reg, cs_reg};
        rd_addr     = idx_reg;
        s_tready    = (state_reg == S_IDLE);
        tmp         = '0;

        case (state_reg)
            S_INIT:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = {1'b1, INIT_P, AW'(0)};
                count_next = CNW'(1);
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next   = s_tuser;
                    addr_next   = s_tdata[19:0];
                    size_next   = in_size;
                    reloc_next  = 1'b0;
                    rstat_next  = STATUS_DONE;
                    raddr_next  = '0;
                    rsize_next  = '0;
                    rmoved_next = 1'b0;
                    rcopy_next  = '0;
                    if ((s_tuser == KIND_ALLOC) ||
                        ((s_tuser == KIND_RESIZE) && (s_tdata[19:0] == 20'd0)))
                    begin
                        mode_next  = SCAN_FREE;
                        ret_next   = S_AL_FOUND;
                        state_next = S_SCAN0;
                    end
                    else if (s_tdata[19:0] == 20'd0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mode_next  = SCAN_USED;
                        ret_next   = S_DISP;
                        state_next = S_SCAN0;
                    end
                end
            end

            S_SCAN0:
            begin
                rd_addr    = '0;
                pv_next    = 1'b1;
                cmp_next   = '0;
                scan_next  = CNW'(1);
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // Reads are issued one entry ahead of the compare.
                rd_addr   = scan_reg[IW-1:0];
                pv_next   = (scan_reg < count_reg);
                cmp_next  = scan_reg[IW-1:0];
                scan_next = scan_reg + CNW'(1);
                if (hit)
                begin
                    idx_next   = cmp_reg;
                    cs_next    = rd_s;
                    cp_next    = rd_p;
                    cf_next    = rd_f;
                    state_next = ret_reg;
                end
                else if (!pv_reg)
                begin
                    if (mode_reg == SCAN_FREE)
                    begin
                        rstat_next = STATUS_NO_SPACE;
                    end
                    else if (!reloc_reg)
                    begin
                        rstat_next = STATUS_UNKNOWN;
                    end
                    state_next = S_DONE;
                end
            end

            S_DISP:
            begin
                case (kind_reg)
                    KIND_RELEASE:
                    begin
                        state_next = S_REL0;
                    end
                    KIND_QUERY:
                    begin
                        raddr_next = addr_reg;
                        rsize_next = CW'(cp_reg) > CW'(0) ? 21'(CW'(cp_reg)) : 21'd0;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        if (size_reg == '0)
                        begin
                            state_next = S_REL0;
                        end
                        else if (size_reg <= CW'(cp_reg))
                        begin
                            sret_next  = S_RS_RES;
                            state_next = S_SP_CHK;
                        end
                        else
                        begin
                            state_next = S_RS_RD;
                        end
                    end
                endcase
            end

            S_RS_RD:
            begin
                rd_addr    = idx_p1[IW-1:0];
                state_next = S_RS_CHK;
            end

            S_RS_CHK:
            begin
                if ((idx_p1 < count_reg) && rd_f && (cp_plus_next >= size_reg))
                begin
                    // Grow in place: absorb the free neighbor, then trim.
                    cp_next    = cp_plus_next[AW-1:0];
                    j_next     = idx_p1[IW-1:0];
                    ret_next   = S_SP_CHK;
                    sret_next  = S_RS_RES;
                    state_next = S_REM_RD;
                end
                else
                begin
                    old_next   = cp_reg;
                    reloc_next = 1'b1;
                    mode_next  = SCAN_FREE;
                    ret_next   = S_AL_FOUND;
                    state_next = S_SCAN0;
                end
            end

            S_RS_RES:
            begin
                raddr_next = addr_reg;
                rsize_next = 21'(CW'(cp_reg));
                state_next = S_DONE;
            end

            S_AL_FOUND:
            begin
                cf_next    = 1'b0;
                sret_next  = S_AL_RES;
                state_next = S_SP_CHK;
            end

            S_AL_RES:
            begin
                tmp        = CW'(cs_reg) + HDR;
                raddr_next = tmp[19:0];
                rsize_next = 21'(CW'(cp_reg));
                if (reloc_reg)
                begin
                    // The old block may have shifted; look it up again.
                    rmoved_next = 1'b1;
                    rcopy_next  = 21'(CW'(old_reg));
                    mode_next   = SCAN_USED;
                    ret_next    = S_REL0;
                    state_next  = S_SCAN0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SP_CHK:
            begin
                if ((count_reg >= MAX_CNT) ||
                    (CW'(cp_reg) < (size_reg + HDR + CW'(margin_reg))))
                begin
                    state_next = S_SP_WB;
                end
                else if (idx_p1 == count_reg)
                begin
                    state_next = S_SP_INS;
                end
                else
                begin
                    j_next     = IW'(count_reg - CNW'(1));
                    state_next = S_SU_RD;
                end
            end

            S_SU_RD:
            begin
                rd_addr    = j_reg;
                state_next = S_SU_WR;
            end

            S_SU_WR:
            begin
                we     = 1'b1;
                waddr  = j_p1[IW-1:0];
                wdata  = rdata;
                j_next = j_reg - IW'(1);
                if ((j_reg - IW'(1)) == idx_reg)
                begin
                    state_next = S_SP_INS;
                end
                else
                begin
                    state_next = S_SU_RD;
                end
            end

            S_SP_INS:
            begin
                tmp        = CW'(cs_reg) + HDR + size_reg;
                ns_next    = tmp[AW-1:0];
                tmp        = CW'(cp_reg) - size_reg - HDR;
                np_next    = tmp[AW-1:0];
                we         = 1'b1;
                waddr      = idx_p1[IW-1:0];
                wdata      = {1'b1, tmp[AW-1:0], ns_next};
                cp_next    = size_reg[AW-1:0];
                count_next = count_reg + CNW'(1);
                rd_addr    = idx_p2[IW-1:0];
                state_next = S_SP_M;
            end

            S_SP_M:
            begin
                if ((idx_p2 < count_reg) && rd_f)
                begin
                    // The leftover touches a free block; fold them together.
                    tmp        = CW'(np_reg) + HDR + CW'(rd_p);
                    we         = 1'b1;
                    waddr      = idx_p1[IW-1:0];
                    wdata      = {1'b1, tmp[AW-1:0], ns_reg};
                    j_next     = idx_p2[IW-1:0];
                    ret_next   = S_SP_WB;
                    state_next = S_REM_RD;
                end
                else
                begin
                    state_next = S_SP_WB;
                end
            end

            S_SP_WB:
            begin
                we         = 1'b1;
                waddr      = idx_reg;
                wdata      = {cf_reg, cp_reg, cs_reg};
                state_next = sret_reg;
            end

            S_REM_RD:
            begin
                if (j_p1 >= count_reg)
                begin
                    count_next = count_reg - CNW'(1);
                    state_next = ret_reg;
                end
                else
                begin
                    rd_addr    = j_p1[IW-1:0];
                    state_next = S_REM_WR;
                end
            end

            S_REM_WR:
            begin
                we         = 1'b1;
                waddr      = j_reg;
                wdata      = rdata;
                j_next     = j_p1[IW-1:0];
                state_next = S_REM_RD;
            end

            S_REL0:
            begin
                cf_next    = 1'b1;
                we         = 1'b1;
                waddr      = idx_reg;
                wdata      = {1'b1, cp_reg, cs_reg};
                rd_addr    = idx_p1[IW-1:0];
                state_next = S_REL1;
            end

            S_REL1:
            begin
                if ((idx_p1 < count_reg) && rd_f)
                begin
                    cp_next    = cp_plus_next[AW-1:0];
                    we         = 1'b1;
                    waddr      = idx_reg;
                    wdata      = {1'b1, cp_plus_next[AW-1:0], cs_reg};
                    j_next     = idx_p1[IW-1:0];
                    ret_next   = S_REL2;
                    state_next = S_REM_RD;
                end
                else
                begin
                    state_next = S_REL2;
                end
            end

            S_REL2:
            begin
                if (idx_reg != '0)
                begin
                    rd_addr    = idx_reg - IW'(1);
                    state_next = S_REL3;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_REL3:
            begin
                if (rd_f)
                begin
                    we         = 1'b1;
                    waddr      = idx_reg - IW'(1);
                    wdata      = {1'b1, cp_plus_next[AW-1:0], rd_s};
                    j_next     = idx_reg;
                    ret_next   = S_DONE;
                    state_next = S_REM_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    muser_next  = rstat_reg;
                    mdata_next  = {1'b0, rcopy_reg, rmoved_reg, rsize_reg, raddr_reg};
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = muser_reg;
    assign m_tdata  = mdata_reg;

`include "first_fit_block_allocator_top_defines.svh"

    // The table never holds more entries than it has rows, and never none.
    `FFBA_ASSERT_ALWAYS(a_count_range,
        (state_reg == S_INIT) || ((count_reg != '0) && (count_reg <= MAX_CNT)),
        "block count out of range")

    // An accepted request always starts work; the block leaves idle.
    `FFBA_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != S_IDLE,
        "request accepted but sequencer stayed idle")

    // No status beyond the three defined codes is ever presented.
    `FFBA_ASSERT_ALWAYS(a_status_code,
        !m_tvalid || (m_tuser == STATUS_DONE) || (m_tuser == STATUS_NO_SPACE) ||
        (m_tuser == STATUS_UNKNOWN),
        "undefined status code")

endmodule

`default_nettype wire
